// ===== hdl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// sfd_pkg: shared types and constants of the serial frame decoder.
// No dependencies; used by the parser and the top level.
package sfd_pkg;

  // Frame header bytes
  localparam logic [7:0] HDR_FIRST  = 8'hC6;
  localparam logic [7:0] HDR_SECOND = 8'hA2;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PAYLOAD  = 128;
  localparam int DEF_NUM_COMMANDS = 16;

  // Width of the handler mask register (one bit per command code)
  localparam int MASK_W = 16;

  // One result item as it leaves the parser
  typedef struct packed {
    logic [7:0] data_byte;
    logic [6:0] position;
    logic       frame_end;
    logic       checksum_ok;
    logic       dispatched;
    logic [7:0] frame_length;
  } sfd_result_t;

endpackage

// ===== hdl/sfd_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the serial frame decoder:
// received bytes, result items and the handler mask write port. No dependencies.
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [6:0] position;
  logic       frame_end;
  logic       checksum_ok;
  logic       dispatched;
  logic [7:0] frame_length;

  modport source (output valid, output data_byte, output position, output frame_end,
                  output checksum_ok, output dispatched, output frame_length,
                  input ready);
  modport sink   (input valid, input data_byte, input position, input frame_end,
                  input checksum_ok, input dispatched, input frame_length,
                  output ready);
endinterface

interface sfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] handler_mask;

  modport source (output valid, output handler_mask, input ready);
  modport sink   (input valid, input handler_mask, output ready);
endinterface

// ===== hdl/sfd_parser.sv =====
`timescale 1ns / 1ps
// sfd_parser: frame state machine, running checksum and result formation.
// Depends on sfd_pkg.
module sfd_parser
  import sfd_pkg::*;
#(
  parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD,
  parameter int NUM_COMMANDS = DEF_NUM_COMMANDS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [MASK_W-1:0]   handler_mask,
  output logic                result_valid,
  output sfd_result_t         result
);

  localparam logic [2:0] PH_HUNT1   = 3'd0;
  localparam logic [2:0] PH_HUNT2   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  localparam logic [7:0] MAX_LEN  = 8'(MAX_PAYLOAD);
  localparam logic [7:0] NUM_CMDS = 8'(NUM_COMMANDS);

  logic [2:0] phase, phase_next;
  logic [7:0] expected_length, expected_length_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] command_code, command_code_next;
  logic [7:0] count_inc;
  logic       sum_match;
  logic       has_handler;

  assign count_inc = byte_count + 8'd1;
  assign sum_match = (~running_sum == rx_byte);
  // Commands past the mask width or past the command count never dispatch
  assign has_handler = (command_code < NUM_CMDS) && (command_code[7:4] == 4'd0) &&
                       handler_mask[command_code[3:0]];

  // One step of the frame parser per byte
  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    byte_count_next      = byte_count;
    running_sum_next     = running_sum;
    command_code_next    = command_code;
    result_valid         = 1'b0;
    result               = '0;
    unique case (phase)
      PH_HUNT2: begin
        phase_next = (rx_byte == HDR_SECOND) ? PH_LENGTH : PH_HUNT1;
      end
      PH_LENGTH: begin
        if (rx_byte == 8'd0 || rx_byte > MAX_LEN) begin
          phase_next = PH_HUNT1;
        end else begin
          expected_length_next = rx_byte;
          byte_count_next      = 8'd0;
          running_sum_next     = HDR_FIRST + HDR_SECOND + rx_byte;
          phase_next           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (byte_count == 8'd0) begin
          command_code_next = rx_byte;
        end
        running_sum_next   = running_sum + rx_byte;
        byte_count_next    = count_inc;
        result_valid       = 1'b1;
        result.data_byte   = rx_byte;
        result.position    = byte_count[6:0];
        if (count_inc >= expected_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result_valid        = 1'b1;
        result.frame_end    = 1'b1;
        result.checksum_ok  = sum_match;
        result.dispatched   = sum_match && has_handler;
        result.frame_length = expected_length;
        phase_next          = PH_HUNT1;
      end
      default: begin
        // hunting the first header; unused codes land here too
        phase_next = (rx_byte == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT1;
      expected_length <= 8'd0;
      byte_count      <= 8'd0;
      running_sum     <= 8'd0;
      command_code    <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      byte_count      <= byte_count_next;
      running_sum     <= running_sum_next;
      command_code    <= command_code_next;
    end
  end

endmodule

// ===== hdl/serial_frame_decoder.sv =====
`timescale 1ns / 1ps
// serial_frame_decoder: top level with input stage, handler mask and result register.
// Depends on sfd_pkg, sfd_channels and sfd_parser.

// Byte-serial frame decoder. Frames are 0xC6, 0xA2, a length L (1..MAX_PAYLOAD),
// L payload bytes (the first is the command) and a checksum byte equal to the
// inverted 8-bit sum of headers, length and payload. Each payload byte comes out
// as one item with its position; the checksum byte gives one frame-end item with
// checksum_ok, dispatched and the frame length. Header and length bytes, and bad
// lengths, give no item. One received byte is taken every cycle unless the input
// stalls: a byte passes an input register, the combinational parser logic and the
// result register. Input stalls only when the input register holds a byte and the
// result register is full and not taken.
// The handler mask is written on the cfg port, which is always ready; write it
// only while no frame is in flight.
module serial_frame_decoder
  import sfd_pkg::*;
#(
  parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD,
  parameter int NUM_COMMANDS = DEF_NUM_COMMANDS
) (
  input logic       clk,
  input logic       rst,
  sfd_rx_if.sink    rx,
  sfd_res_if.source res,
  sfd_cfg_if.sink   cfg
);

  logic              stage_valid;
  logic [7:0]        stage_byte;
  logic [MASK_W-1:0] handler_mask;
  logic              out_valid;
  sfd_result_t       out_q;
  logic              out_free;
  logic              advance;
  logic              step_valid;
  sfd_result_t       step_result;

  assign out_free = !out_valid || res.ready;
  assign advance  = stage_valid && out_free;
  assign rx.ready = !stage_valid || out_free;
  assign cfg.ready = 1'b1;

  // Handler mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      handler_mask <= '0;
    end else if (cfg.valid) begin
      handler_mask <= cfg.handler_mask;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx.ready) begin
      stage_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      stage_byte <= rx.rx_byte;
    end
  end

  sfd_parser #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .NUM_COMMANDS (NUM_COMMANDS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .rx_byte      (stage_byte),
    .handler_mask (handler_mask),
    .result_valid (step_valid),
    .result       (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_valid) begin
      out_q <= step_result;
    end
  end

  assign res.valid        = out_valid;
  assign res.data_byte    = out_q.data_byte;
  assign res.position     = out_q.position;
  assign res.frame_end    = out_q.frame_end;
  assign res.checksum_ok  = out_q.checksum_ok;
  assign res.dispatched   = out_q.dispatched;
  assign res.frame_length = out_q.frame_length;

endmodule
